FILE: rtl/framed_message_queue_assert.svh
// Assertion shorthands used by the checker file.
`ifndef FRAMED_MESSAGE_QUEUE_ASSERT_SVH
`define FRAMED_MESSAGE_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FMQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmq check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define FMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmq check failed");

`endif

FILE: rtl/fmq_pkg.sv
package fmq_pkg;

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

endpackage

FILE: rtl/fmq_byte_ram.sv
// Byte ring storage: one write port, one read port, registered read data.
module fmq_byte_ram #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/framed_message_queue.sv
// Framed message queue: a byte ring that holds whole messages, plus a small
// ring of end-of-record marks (index of each complete message's last byte).
//
// Input channel: an item is taken on a rising edge with start high and busy
// low. func selects a byte write or a read of the oldest complete message.
// Result channel: every result is shown for exactly one cycle with strobe
// high; run_last flags the final result of an item. msg_count and free_bytes
// always show the queue as it stands after the item.
//
// Timing: a write gives its single result from the registered S_WRITE state,
// and busy drops in the cycle its result is shown. A read first passes a
// setup state (mark lookup, length and pointer update), then streams the
// message out of the byte RAM one byte per cycle; the registered RAM read
// and the output register lie between the run state and each shown byte,
// and busy drops in the cycle the last byte is shown. An empty read or a
// zero copy limit gives one result, straight from the setup state. The
// single RAM read port sets the one byte per cycle stream rate.
// Reset (rst, synchronous) empties both rings and clears the drop state; the
// byte and mark storage is not cleared. The receiver cannot stall: results
// are never held back.
module framed_message_queue import fmq_pkg::*; #(
  parameter int BUF_DEPTH  = 128,
  parameter int MARK_DEPTH = 8,
  parameter int MAX_RUN    = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       func,
  input  logic [7:0] wr_byte,
  input  logic       wr_first,
  input  logic       wr_last,
  input  logic [7:0] msg_len,
  input  logic [6:0] copy_limit,
  output logic       strobe,
  output logic [7:0] rd_byte,
  output logic       rd_valid,
  output logic       run_last,
  output logic [1:0] status,
  output logic [7:0] full_len,
  output logic [2:0] msg_count,
  output logic [7:0] free_bytes
);

  localparam int BA  = $clog2(BUF_DEPTH);       // byte ring index
  localparam int CW  = $clog2(BUF_DEPTH + 1);   // byte count / length
  localparam int MA  = $clog2(MARK_DEPTH);      // mark ring index
  localparam int MCW = $clog2(MARK_DEPTH);      // mark count, max MARK_DEPTH-1
  localparam int RW  = $clog2(MAX_RUN + 1);     // copy run counter

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_RD_SETUP,
    S_RD_RUN,
    S_RD_TAIL
  } state_t;

  state_t state;

  // ring state
  logic [BA-1:0]  byte_rd_ptr;
  logic [BA-1:0]  byte_wr_ptr;
  logic [CW-1:0]  byte_count;
  logic [BA-1:0]  mark_store [MARK_DEPTH];
  logic [MA-1:0]  mark_rd_ptr;
  logic [MA-1:0]  mark_wr_ptr;
  logic [MCW-1:0] mark_count;
  logic           dropping;

  // captured item
  logic       op_first;
  logic       op_last;
  logic [7:0] op_byte;
  logic [7:0] op_len;
  logic [6:0] op_limit;

  // read sequencer
  logic [BA-1:0] cp;
  logic [RW-1:0] remaining;
  logic [CW-1:0] flen;
  logic          pend;
  logic          pend_last;
  logic [7:0]    ram_q;

  // write decision
  logic [CW-1:0] free_cnt;
  logic          mark_full;
  logic          drop_now;
  logic          wr_ok;
  status_t       wr_status;
  logic [BA-1:0] wr_ptr_next;
  logic [MA-1:0] mark_wr_next;

  // read setup
  logic [BA-1:0] mark_pos;
  logic [CW-1:0] len_calc;
  logic [RW-1:0] lim_sat;
  logic [RW-1:0] ncopy;
  logic [BA-1:0] rd_ptr_next;
  logic [MA-1:0] mark_rd_next;
  logic [BA-1:0] cp_next;

  assign busy       = (state != S_IDLE);
  assign msg_count  = 3'(mark_count);
  assign free_bytes = 8'(free_cnt);

  assign free_cnt  = CW'(BUF_DEPTH) - byte_count;
  assign mark_full = (mark_count >= MCW'(MARK_DEPTH - 1));

  always_comb begin
    if (op_first) begin
      drop_now = (16'(op_len) > 16'(free_cnt)) || mark_full;
    end else begin
      drop_now = dropping;
    end
    wr_ok = !drop_now && (byte_count < CW'(BUF_DEPTH)) && !(op_last && mark_full);
    wr_status = wr_ok ? ST_OK : ST_REJECT;
  end

  assign wr_ptr_next  = (byte_wr_ptr == BA'(BUF_DEPTH - 1)) ? '0 : byte_wr_ptr + 1'b1;
  assign mark_wr_next = (mark_wr_ptr == MA'(MARK_DEPTH - 1)) ? '0 : mark_wr_ptr + 1'b1;
  assign mark_rd_next = (mark_rd_ptr == MA'(MARK_DEPTH - 1)) ? '0 : mark_rd_ptr + 1'b1;
  assign mark_pos     = mark_store[mark_rd_ptr];
  assign rd_ptr_next  = (mark_pos == BA'(BUF_DEPTH - 1)) ? '0 : mark_pos + 1'b1;
  assign cp_next      = (cp == BA'(BUF_DEPTH - 1)) ? '0 : cp + 1'b1;

  // Message length from head pointer to end mark (wraps once) and copy count.
  always_comb begin
    if (byte_rd_ptr > mark_pos) begin
      len_calc = CW'(BUF_DEPTH + 1) + CW'(mark_pos) - CW'(byte_rd_ptr);
    end else begin
      len_calc = CW'(mark_pos) + CW'(1) - CW'(byte_rd_ptr);
    end
    lim_sat = (op_limit > 7'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(op_limit);
    ncopy = (16'(len_calc) < 16'(lim_sat)) ? RW'(len_calc) : lim_sat;
  end

  fmq_byte_ram #(
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (state == S_WRITE && wr_ok),
    .waddr (byte_wr_ptr),
    .wdata (op_byte),
    .raddr (cp),
    .rdata (ram_q)
  );

  // Mark ring storage, no reset.
  always_ff @(posedge clk) begin
    if (state == S_WRITE && wr_ok && op_last) begin
      mark_store[mark_wr_ptr] <= byte_wr_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_rd_ptr <= '0;
      byte_wr_ptr <= '0;
      byte_count  <= '0;
      mark_rd_ptr <= '0;
      mark_wr_ptr <= '0;
      mark_count  <= '0;
      dropping    <= 1'b0;
      pend        <= 1'b0;
      pend_last   <= 1'b0;
      strobe      <= 1'b0;
      rd_valid    <= 1'b0;
      run_last    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      pend   <= 1'b0;

      // the byte read when pend was set is now on ram_q
      if (pend) begin
        strobe   <= 1'b1;
        rd_byte  <= ram_q;
        rd_valid <= 1'b1;
        run_last <= pend_last;
        status   <= ST_OK;
        full_len <= 8'(flen);
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            op_first <= wr_first;
            op_last  <= wr_last;
            op_byte  <= wr_byte;
            op_len   <= msg_len;
            op_limit <= copy_limit;
            state    <= (func == FUNC_READ) ? S_RD_SETUP : S_WRITE;
          end
        end
        S_WRITE: begin
          dropping <= drop_now;
          if (wr_ok) begin
            byte_wr_ptr <= wr_ptr_next;
            byte_count  <= byte_count + 1'b1;
            if (op_last) begin
              mark_wr_ptr <= mark_wr_next;
              mark_count  <= mark_count + 1'b1;
            end
          end
          strobe   <= 1'b1;
          rd_byte  <= '0;
          rd_valid <= 1'b0;
          run_last <= 1'b1;
          status   <= wr_status;
          full_len <= '0;
          state    <= S_IDLE;
        end
        S_RD_SETUP: begin
          if (mark_count == '0) begin
            strobe   <= 1'b1;
            rd_byte  <= '0;
            rd_valid <= 1'b0;
            run_last <= 1'b1;
            status   <= ST_EMPTY;
            full_len <= '0;
            state    <= S_IDLE;
          end else begin
            byte_rd_ptr <= rd_ptr_next;
            byte_count  <= (byte_count >= len_calc) ? byte_count - len_calc : '0;
            mark_rd_ptr <= mark_rd_next;
            mark_count  <= mark_count - 1'b1;
            cp          <= byte_rd_ptr;
            remaining   <= ncopy;
            flen        <= len_calc;
            if (ncopy == '0) begin
              // zero copy limit: message dropped, one status result
              strobe   <= 1'b1;
              rd_byte  <= '0;
              rd_valid <= 1'b0;
              run_last <= 1'b1;
              status   <= ST_OK;
              full_len <= 8'(len_calc);
              state    <= S_IDLE;
            end else begin
              state <= S_RD_RUN;
            end
          end
        end
        S_RD_RUN: begin
          cp        <= cp_next;
          remaining <= remaining - 1'b1;
          pend      <= 1'b1;
          pend_last <= (remaining == RW'(1));
          if (remaining == RW'(1)) begin
            state <= S_RD_TAIL;
          end
        end
        S_RD_TAIL: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/fmq_checker.sv
`include "framed_message_queue_assert.svh"

module fmq_checker import fmq_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic       rd_valid,
  input logic       run_last,
  input logic [1:0] status
);

  // a taken item always holds the block for at least the next cycle
  `FMQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // a delivered byte always carries ok status
  `FMQ_ASSERT_NOW(a_valid_ok, strobe && rd_valid, status == ST_OK)
  // rejected writes and empty reads end their item in one result
  `FMQ_ASSERT_NOW(a_err_single, strobe && status != ST_OK, run_last && !rd_valid)
  // a byte run has no gaps until its last result
  `FMQ_ASSERT_NEXT(a_run_gapless, strobe && !run_last, strobe && rd_valid)
  // the block frees up no later than its final result
  `FMQ_ASSERT_NOW(a_last_idle, strobe && run_last, !busy)

endmodule

bind framed_message_queue fmq_checker u_fmq_checker (.*);

FILE: bench/tb_framed_message_queue.sv
module tb_framed_message_queue;
  import fmq_pkg::*;

  localparam int RING_BYTES  = 128;    // byte ring size
  localparam int MARK_SLOTS  = 8;      // end-mark ring size, one slot kept open
  localparam int MAX_COPY    = 64;     // copy limit saturates here
  localparam int ITEM_GOAL   = 470;
  localparam int TAIL_CYCLES = 12;     // quiet time after the last result
  localparam int CYCLE_LIMIT = 300000;

  // One result as it appears on the result ports.
  typedef struct packed {
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       run_last;
    logic [1:0] status;
    logic [7:0] full_len;
    logic [2:0] msg_count;
    logic [7:0] free_bytes;
  } queue_result_t;

  // Mirror of the queue: byte ring, end-mark ring and the drop flag. Every
  // accepted item is applied here and the results it must cause are queued.
  class message_queue_mirror;
    bit [7:0]      ring [RING_BYTES];
    bit [6:0]      head;        // oldest stored byte
    bit [6:0]      tail;        // next free byte slot
    int unsigned   held;        // bytes stored
    bit [6:0]      ends [MARK_SLOTS];
    bit [2:0]      ends_rd;
    bit [2:0]      ends_wr;
    int unsigned   ends_held;   // complete messages
    bit            dropping;
    queue_result_t due[$];
    int            errors;

    // Counts and free space are taken as they stand after the item.
    function void push_result(bit [7:0] b, bit valid, bit run_end, status_t s,
                              bit [7:0] flen);
      queue_result_t r;
      r.rd_byte    = b;
      r.rd_valid   = valid;
      r.run_last   = run_end;
      r.status     = s;
      r.full_len   = flen;
      r.msg_count  = 3'(ends_held);
      r.free_bytes = 8'(RING_BYTES - held);
      due.push_back(r);
    endfunction

    function void apply_item(func_t f, bit [7:0] b, bit first, bit last,
                             bit [7:0] mlen, bit [6:0] climit);
      status_t     s;
      bit [6:0]    rp;
      bit [6:0]    mark;
      bit [6:0]    span;
      int unsigned flen;
      int unsigned ncopy;
      if (f == FUNC_WRITE) begin
        s = ST_OK;
        // a first byte decides whether the whole message is taken
        if (first)
          dropping = (mlen > RING_BYTES - held) || (ends_held >= MARK_SLOTS - 1);
        if (dropping || held >= RING_BYTES || (last && ends_held >= MARK_SLOTS - 1)) begin
          s = ST_REJECT;
        end else begin
          ring[tail] = b;
          if (last) begin
            ends[ends_wr] = tail;
            ends_wr++;
            ends_held++;
          end
          tail++;
          held++;
        end
        push_result(8'd0, 1'b0, 1'b1, s, 8'd0);
      end else if (ends_held == 0) begin
        push_result(8'd0, 1'b0, 1'b1, ST_EMPTY, 8'd0);
      end else begin
        ncopy = (climit > MAX_COPY) ? MAX_COPY : climit;
        rp    = head;
        mark  = ends[ends_rd];
        span  = mark - rp;           // wraps on the 7-bit ring index
        flen  = span + 1;
        if (flen < ncopy) ncopy = flen;
        head      = mark + 7'd1;
        held      = (held >= flen) ? held - flen : 0;
        ends_rd++;
        ends_held--;
        if (ncopy == 0) begin
          push_result(8'd0, 1'b0, 1'b1, ST_OK, 8'(flen));
        end else begin
          for (int i = 0; i < ncopy; i++) begin
            push_result(ring[rp], 1'b1, i == ncopy - 1, ST_OK, 8'(flen));
            rp++;
          end
        end
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %0d valid %0d status %0d",
                 $time, got.rd_byte, got.rd_valid, got.status);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("rd_byte",    want.rd_byte,        got.rd_byte);
      compare_field("rd_valid",   8'(want.rd_valid),   8'(got.rd_valid));
      compare_field("run_last",   8'(want.run_last),   8'(got.run_last));
      compare_field("status",     8'(want.status),     8'(got.status));
      compare_field("full_len",   want.full_len,       got.full_len);
      compare_field("msg_count",  8'(want.msg_count),  8'(got.msg_count));
      compare_field("free_bytes", want.free_bytes,     got.free_bytes);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       func = FUNC_WRITE;
  logic [7:0] wr_byte = 8'd0;
  logic       wr_first = 1'b0;
  logic       wr_last = 1'b0;
  logic [7:0] msg_len = 8'd0;
  logic [6:0] copy_limit = 7'd0;
  logic       strobe;
  logic [7:0] rd_byte;
  logic       rd_valid;
  logic       run_last;
  logic [1:0] status;
  logic [7:0] full_len;
  logic [2:0] msg_count;
  logic [7:0] free_bytes;

  message_queue_mirror mirror;
  int sent;          // items accepted so far
  bit no_idle;       // back-to-back stretch: sender never pauses
  int cycles;

  framed_message_queue dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Hard stop in case the block hangs or never drops busy.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb_framed_message_queue: done, errors");
    $finish;
  end

  // Results cannot be held off, so every strobe cycle is checked at the edge
  // that ends it.
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1)
      mirror.check_result({rd_byte, rd_valid, run_last, status, full_len,
                           msg_count, free_bytes});
  end

  // Present one item after a random pause, hold it until an edge with busy
  // low takes it, then update the mirror. Inputs move on falling edges only.
  task automatic send_item(func_t f, bit [7:0] b, bit first, bit last,
                           bit [7:0] mlen, bit [6:0] climit);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func       = f;
    wr_byte    = b;
    wr_first   = first;
    wr_last    = last;
    msg_len    = mlen;
    copy_limit = climit;
    start      = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.apply_item(f, b, first, last, mlen, climit);
    sent++;
  endtask

  // Write fields carry noise on a read; the block must ignore them.
  task automatic send_read(bit [6:0] climit);
    send_item(FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), climit);
  endtask

  // A run of write items. Length is only meaningful on the first byte, so
  // the others get noise there.
  task automatic send_message(int len, bit [7:0] declared, bit has_first,
                              bit has_last);
    for (int i = 0; i < len; i++)
      send_item(FUNC_WRITE, 8'($urandom_range(0, 255)), has_first && i == 0,
                has_last && i == len - 1,
                (i == 0) ? declared : 8'($urandom_range(0, 255)),
                7'($urandom_range(0, 127)));
  endtask

  initial begin
    int read_odds;
    int kind;
    int len;
    int pick;
    bit [6:0] climit;
    mirror = new();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // --- directed part ---
    send_read(7'd1);                                  // read on empty queue
    send_item(FUNC_WRITE, 8'h00, 1'b1, 1'b0, 8'd2, 7'h7f);
    send_item(FUNC_WRITE, 8'hff, 1'b0, 1'b1, 8'hff, 7'h00);
    send_read(7'd127);                                // limit saturates
    send_item(FUNC_WRITE, 8'ha5, 1'b1, 1'b1, 8'd0, 7'd5); // zero length fits
    send_read(7'd0);                                  // discard whole message
    send_item(FUNC_WRITE, 8'h11, 1'b1, 1'b0, 8'd255, 7'd3); // too long: drop
    send_item(FUNC_WRITE, 8'h22, 1'b0, 1'b1, 8'd1, 7'd3);   // still dropping
    send_item(FUNC_WRITE, 8'h5a, 1'b1, 1'b0, 8'd3, 7'd3);   // left open
    send_item(FUNC_WRITE, 8'h3c, 1'b1, 1'b1, 8'd1, 7'd3);   // joins the open one
    send_item(FUNC_WRITE, 8'h81, 1'b0, 1'b0, 8'd0, 7'd3);   // no first byte
    send_item(FUNC_WRITE, 8'h7e, 1'b0, 1'b1, 8'd0, 7'd3);
    send_read(7'd1);                                  // truncated copy
    send_read(7'd64);
    send_read(7'd64);                                 // empty again
    // fill the mark ring, then hit it with a first byte and a last byte
    send_message(6, 8'd6, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++)
      send_message(1, 8'd1, 1'b1, 1'b1);
    send_message(1, 8'd1, 1'b1, 1'b1);                // rejected: ring full
    send_item(FUNC_WRITE, 8'h42, 1'b1, 1'b0, 8'd1, 7'd1); // rejected first
    send_item(FUNC_WRITE, 8'h24, 1'b0, 1'b1, 8'd1, 7'd1); // discarded

    // --- random part ---
    // Phases alternate between balanced traffic, filling (mostly writes, so
    // both rings run full) and draining (mostly reads, many on empty).
    while (sent < ITEM_GOAL) begin
      if ($urandom_range(0, 15) == 0) no_idle = ($urandom_range(0, 2) == 0);
      case ((sent / 100) % 4)
        1:       read_odds = 12;
        2:       read_odds = 65;
        default: read_odds = 35;
      endcase
      if ($urandom_range(0, 99) < read_odds) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      climit = 7'd0;
        else if (pick == 1) climit = 7'($urandom_range(65, 127));
        else                climit = 7'($urandom_range(1, 64));
        send_read(climit);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 13)      len = $urandom_range(1, 8);
        else if (pick < 19) len = $urandom_range(9, 40);
        else                len = $urandom_range(41, 128);
        // keep the item total near the goal
        if (len > ITEM_GOAL - sent) len = ITEM_GOAL - sent;
        kind = $urandom_range(0, 19);
        case (kind)
          0: send_message(1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));          // stray byte
          1: send_message(len, 8'(len), 1'b1, 1'b0);          // never closed
          2: send_message(len, 8'(len), 1'b0, 1'b1);          // no first byte
          3: send_message(len, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
          4: send_message(len, 8'd1, 1'b1, 1'b1);             // longer than said
          default: send_message(len, 8'(len), 1'b1, 1'b1);
        endcase
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (mirror.due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0)
      $display("tb_framed_message_queue: done, clean");
    else
      $display("tb_framed_message_queue: done, errors");
    $finish;
  end

endmodule

FILE: framed_message_queue.f
+incdir+rtl
rtl/fmq_pkg.sv
rtl/fmq_byte_ram.sv
rtl/framed_message_queue.sv
rtl/fmq_checker.sv
bench/tb_framed_message_queue.sv
